@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the segment allocator.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: label failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: label failed");

// Next-cycle implication that is also checked through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: label failed");

`endif

@@ rtl/ffsa_pkg.sv @@
// Shared types and constants of the first-fit segment allocator.
// No dependencies; imported by the core, the checker and the testbench.
package ffsa_pkg;

    // Field widths of the stream payloads.
    localparam int FIELD_BITS   = 16;
    localparam int OP_BITS      = 2;
    localparam int STATUS_BITS  = 2;
    localparam int S_TDATA_BITS = 40;
    localparam int M_TDATA_BITS = 40;

    // Bit positions of the fields inside tdata.
    localparam int S_OP_LSB     = 0;
    localparam int S_SIZE_LSB   = 2;
    localparam int S_ADDR_LSB   = 18;
    localparam int M_FIELDS_TOP = 34;

    // Default sizing of the tables and the address space.
    localparam int DEFAULT_TABLE_ENTRIES = 16;
    localparam int DEFAULT_ADDRESS_BITS  = 16;

    // Reset values of the configuration registers.
    localparam logic [FIELD_BITS-1:0] HEAP_BASE_RESET = 16'd5000;
    localparam logic [FIELD_BITS-1:0] HEAP_SIZE_RESET = 16'(20000 - 5000);

    // Configuration register indexes.
    localparam logic REG_HEAP_BASE = 1'b0;
    localparam logic REG_HEAP_SIZE = 1'b1;

    // Request operation codes.
    localparam logic [OP_BITS-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_INIT    = 2'd2;
    localparam logic [OP_BITS-1:0] OP_UNUSED  = 2'd3;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_NOTALLOC = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

endpackage

@@ rtl/ffsa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the free and the allocated segment tables.
module ffsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/first_fit_segment_allocator_core.sv @@
// Top level of the first-fit segment allocator: sequencer, tables and stream ports.
// Depends on ffsa_pkg and ffsa_ram.
//
// Requests arrive on the s_ stream, one transfer each: allocate, release or
// initialize. Every request except the unused operation code three gives one
// result transfer on the m_ stream. The user must write heap_base and heap_size
// on the cfg_ port only while the block is idle; the block does not enforce it.
// One request is worked on at a time; s_tready is high only when the sequencer
// is idle. A single compare unit walks the tables one entry per cycle through
// the registered RAM read port. Initialize, and allocate of size zero, go
// straight to the result register. Allocate scans every entry and, on an exact
// fit, then moves each entry behind the taken one down. Release scans until it
// finds the segment, then moves each free entry up and writes the released
// segment to the front of the free table.
// The result register holds a finished result while the receiver stalls; the
// sequencer waits in its final step until that register is free.
// After reset both tables are empty, no segment is allocated and the
// configuration registers hold their defaults; no clearing pass is needed.
module first_fit_segment_allocator_core
    import ffsa_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES,
    parameter int ADDRESS_BITS  = DEFAULT_ADDRESS_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Request stream. s_tdata: operation[1:0], request_size[17:2],
    // release_address[33:18], zero[39:34].
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    // Result stream. m_tdata: status[1:0], address[17:2],
    // segment_size[33:18], zero[39:34].
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,
    // Configuration write port.
    input  logic                    cfg_wr_en,
    input  logic                    cfg_index,
    input  logic [FIELD_BITS-1:0]   cfg_wdata
);

    localparam int IXW     = $clog2(TABLE_ENTRIES);
    localparam int IW      = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = ADDRESS_BITS + FIELD_BITS;
    localparam int WIDE    = (ADDRESS_BITS > FIELD_BITS) ? ADDRESS_BITS : FIELD_BITS;
    localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_ENTRIES - 1);
    localparam logic [IW-1:0] ENTRIES_N = IW'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_SCAN,
        S_A_DECIDE,
        S_A_SHIFT,
        S_R_SCAN,
        S_R_SHIFT,
        S_R_HEAD,
        S_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [IW-1:0]           idx_reg, idx_next;
    logic [IW-1:0]           free_count_reg, free_count_next;
    logic [TABLE_ENTRIES-1:0] used_valid_reg, used_valid_next;
    logic [FIELD_BITS-1:0]   heap_base_reg, heap_base_next;
    logic [FIELD_BITS-1:0]   heap_size_reg, heap_size_next;
    logic [FIELD_BITS-1:0]   need_reg, need_next;
    logic                    slot_found_reg, slot_found_next;
    logic [IXW-1:0]          slot_reg, slot_next;
    logic                    fit_found_reg, fit_found_next;
    logic [IXW-1:0]          fit_reg, fit_next;
    logic [ADDRESS_BITS-1:0] seg_start_reg, seg_start_next;
    logic [FIELD_BITS-1:0]   seg_len_reg, seg_len_next;
    status_t                 res_status_reg, res_status_next;
    logic [FIELD_BITS-1:0]   res_addr_reg, res_addr_next;
    logic [FIELD_BITS-1:0]   res_size_reg, res_size_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    // Table ports.
    logic                    free_wr_en;
    logic [IXW-1:0]          free_wr_addr;
    logic [ENTRY_W-1:0]      free_wr_data;
    logic [ENTRY_W-1:0]      free_rd_data;
    logic                    used_wr_en;
    logic [ENTRY_W-1:0]      used_wr_data;
    logic [ENTRY_W-1:0]      used_rd_data;
    logic [IXW-1:0]          rd_addr;

    // Field views and width adaptation.
    logic [OP_BITS-1:0]      in_op;
    logic [FIELD_BITS-1:0]   in_size;
    logic [FIELD_BITS-1:0]   in_addr;
    logic [WIDE-1:0]         base_wide;
    logic [WIDE-1:0]         rel_wide;
    logic [WIDE-1:0]         need_wide;
    logic [WIDE-1:0]         start_wide;
    logic [ADDRESS_BITS-1:0] base_ab;
    logic [ADDRESS_BITS-1:0] rel_ab;
    logic [ADDRESS_BITS-1:0] need_ab;
    logic [FIELD_BITS-1:0]   start_out;
    logic [ADDRESS_BITS-1:0] free_rd_start;
    logic [FIELD_BITS-1:0]   free_rd_len;
    logic [ADDRESS_BITS-1:0] used_rd_start;
    logic [FIELD_BITS-1:0]   used_rd_len;
    logic                    cur_valid;
    logic                    fit_hit;
    logic                    slot_hit;
    logic                    rel_hit;
    logic [IW-1:0]           idx_m1;
    logic [IW-1:0]           idx_p1;
    logic                    s_xfer;

    assign in_op      = s_tdata[S_OP_LSB +: OP_BITS];
    assign in_size    = s_tdata[S_SIZE_LSB +: FIELD_BITS];
    assign in_addr    = s_tdata[S_ADDR_LSB +: FIELD_BITS];
    assign base_wide  = WIDE'(heap_base_reg);
    assign rel_wide   = WIDE'(in_addr);
    assign need_wide  = WIDE'(need_reg);
    assign start_wide = WIDE'(seg_start_reg);
    assign base_ab    = base_wide[ADDRESS_BITS-1:0];
    assign rel_ab     = rel_wide[ADDRESS_BITS-1:0];
    assign need_ab    = need_wide[ADDRESS_BITS-1:0];
    assign start_out  = start_wide[FIELD_BITS-1:0];

    assign free_rd_start = free_rd_data[ENTRY_W-1:FIELD_BITS];
    assign free_rd_len   = free_rd_data[FIELD_BITS-1:0];
    assign used_rd_start = used_rd_data[ENTRY_W-1:FIELD_BITS];
    assign used_rd_len   = used_rd_data[FIELD_BITS-1:0];

    // The shared compare unit: looks at table entry idx_reg in this cycle.
    assign cur_valid = used_valid_reg[idx_reg[IXW-1:0]];
    assign fit_hit   = (idx_reg < free_count_reg) && (free_rd_len >= need_reg);
    assign slot_hit  = !cur_valid;
    assign rel_hit   = cur_valid && (used_rd_start == seg_start_reg);
    assign idx_m1    = idx_reg - 1'b1;
    assign idx_p1    = idx_reg + 1'b1;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Both tables are read at the next index, so the entry for idx_reg is
    // present in the cycle after the index was chosen.
    assign rd_addr = idx_next[IXW-1:0];

    ffsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_free_ram (
        .aclk    (aclk),
        .wr_en   (free_wr_en),
        .wr_addr (free_wr_addr),
        .wr_data (free_wr_data),
        .rd_addr (rd_addr),
        .rd_data (free_rd_data)
    );

    ffsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_used_ram (
        .aclk    (aclk),
        .wr_en   (used_wr_en),
        .wr_addr (slot_reg),
        .wr_data (used_wr_data),
        .rd_addr (rd_addr),
        .rd_data (used_rd_data)
    );

    // Sequencer and table updates.
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        free_count_next = free_count_reg;
        used_valid_next = used_valid_reg;
        heap_base_next  = heap_base_reg;
        heap_size_next  = heap_size_reg;
        need_next       = need_reg;
        slot_found_next = slot_found_reg;
        slot_next       = slot_reg;
        fit_found_next  = fit_found_reg;
        fit_next        = fit_reg;
        seg_start_next  = seg_start_reg;
        seg_len_next    = seg_len_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_size_next   = res_size_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        free_wr_en      = 1'b0;
        free_wr_addr    = '0;
        free_wr_data    = {seg_start_reg, seg_len_reg};
        used_wr_en      = 1'b0;
        used_wr_data    = {seg_start_reg, need_reg};

        // The user must send configuration writes only while idle; the block does not check this.
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HEAP_BASE: heap_base_next = cfg_wdata;
                REG_HEAP_SIZE: heap_size_next = cfg_wdata;
                default:       heap_base_next = heap_base_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                idx_next = '0;
                if (s_xfer) begin
                    unique case (in_op)
                        OP_ALLOC: begin
                            need_next       = in_size;
                            slot_found_next = 1'b0;
                            fit_found_next  = 1'b0;
                            if (in_size == '0) begin
                                res_status_next = ST_NOFIT;
                                res_addr_next   = '0;
                                res_size_next   = '0;
                                state_next      = S_FINISH;
                            end else begin
                                state_next = S_A_SCAN;
                            end
                        end
                        OP_RELEASE: begin
                            seg_start_next = rel_ab;
                            state_next     = S_R_SCAN;
                        end
                        OP_INIT: begin
                            used_valid_next = '0;
                            if (heap_size_reg != '0) begin
                                free_wr_en      = 1'b1;
                                free_wr_data    = {base_ab, heap_size_reg};
                                free_count_next = IW'(1);
                            end else begin
                                free_count_next = '0;
                            end
                            res_status_next = ST_OK;
                            res_addr_next   = heap_base_reg;
                            res_size_next   = heap_size_reg;
                            state_next      = S_FINISH;
                        end
                        default: begin
                            // The unused operation code is dropped without a result.
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Walk all entries: first free used slot and first free segment that fits.
            S_A_SCAN: begin
                if (!slot_found_reg && slot_hit) begin
                    slot_found_next = 1'b1;
                    slot_next       = idx_reg[IXW-1:0];
                end
                if (!fit_found_reg && fit_hit) begin
                    fit_found_next = 1'b1;
                    fit_next       = idx_reg[IXW-1:0];
                    seg_start_next = free_rd_start;
                    seg_len_next   = free_rd_len;
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = S_A_DECIDE;
                end else begin
                    idx_next = idx_p1;
                end
            end

            // Grant from the chosen segment, or report why not.
            S_A_DECIDE: begin
                idx_next = IW'(fit_reg) + 1'b1;
                if (!slot_found_reg) begin
                    res_status_next = ST_FULL;
                    res_addr_next   = '0;
                    res_size_next   = '0;
                    state_next      = S_FINISH;
                end else if (!fit_found_reg) begin
                    res_status_next = ST_NOFIT;
                    res_addr_next   = '0;
                    res_size_next   = '0;
                    state_next      = S_FINISH;
                end else begin
                    used_wr_en                = 1'b1;
                    used_valid_next[slot_reg] = 1'b1;
                    res_status_next           = ST_OK;
                    res_addr_next             = start_out;
                    res_size_next             = need_reg;
                    if (seg_len_reg == need_reg) begin
                        state_next = S_A_SHIFT;
                    end else begin
                        free_wr_en   = 1'b1;
                        free_wr_addr = fit_reg;
                        free_wr_data = {seg_start_reg + need_ab, seg_len_reg - need_reg};
                        state_next   = S_FINISH;
                    end
                end
            end

            // Exact fit: move the entries behind the taken one down by one.
            S_A_SHIFT: begin
                if (idx_reg < free_count_reg) begin
                    free_wr_en   = 1'b1;
                    free_wr_addr = idx_m1[IXW-1:0];
                    free_wr_data = free_rd_data;
                    idx_next     = idx_p1;
                end else begin
                    free_count_next = free_count_reg - 1'b1;
                    state_next      = S_FINISH;
                end
            end

            // Look up the allocated segment by its start address.
            S_R_SCAN: begin
                if (rel_hit) begin
                    slot_next    = idx_reg[IXW-1:0];
                    seg_len_next = used_rd_len;
                    if (free_count_reg >= ENTRIES_N) begin
                        res_status_next = ST_FULL;
                        res_addr_next   = '0;
                        res_size_next   = '0;
                        state_next      = S_FINISH;
                    end else if (free_count_reg == '0) begin
                        state_next = S_R_HEAD;
                    end else begin
                        idx_next   = free_count_reg - 1'b1;
                        state_next = S_R_SHIFT;
                    end
                end else if (idx_reg == LAST_IDX) begin
                    res_status_next = ST_NOTALLOC;
                    res_addr_next   = '0;
                    res_size_next   = '0;
                    state_next      = S_FINISH;
                end else begin
                    idx_next = idx_p1;
                end
            end

            // Move the live free entries up by one, from the back.
            S_R_SHIFT: begin
                free_wr_en   = 1'b1;
                free_wr_addr = idx_p1[IXW-1:0];
                free_wr_data = free_rd_data;
                if (idx_reg == '0) begin
                    state_next = S_R_HEAD;
                end else begin
                    idx_next = idx_m1;
                end
            end

            // Put the released segment at the front of the free table.
            S_R_HEAD: begin
                free_wr_en                = 1'b1;
                free_count_next           = free_count_reg + 1'b1;
                used_valid_next[slot_reg] = 1'b0;
                res_status_next           = ST_OK;
                res_addr_next             = start_out;
                res_size_next             = seg_len_reg;
                state_next                = S_FINISH;
            end

            // Hand the result over once the output register is free.
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(M_TDATA_BITS - M_FIELDS_TOP)'(0), res_size_reg,
                                     res_addr_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // State, counters and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            free_count_reg <= '0;
            used_valid_reg <= '0;
            heap_base_reg  <= HEAP_BASE_RESET;
            heap_size_reg  <= HEAP_SIZE_RESET;
            slot_found_reg <= 1'b0;
            fit_found_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            free_count_reg <= free_count_next;
            used_valid_reg <= used_valid_next;
            heap_base_reg  <= heap_base_next;
            heap_size_reg  <= heap_size_next;
            slot_found_reg <= slot_found_next;
            fit_found_reg  <= fit_found_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        need_reg       <= need_next;
        slot_reg       <= slot_next;
        fit_reg        <= fit_next;
        seg_start_reg  <= seg_start_next;
        seg_len_reg    <= seg_len_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_size_reg   <= res_size_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

@@ rtl/ffsa_checker.sv @@
// Port-level checker of the first-fit segment allocator, bound to the top level.
// Depends on ffsa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffsa_checker
    import ffsa_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic [S_TDATA_BITS-1:0] s_tdata,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata
);

    // Field views of the two streams.
    logic [OP_BITS-1:0]      s_op;
    logic                    s_xfer;
    logic [STATUS_BITS-1:0]  m_status;
    logic [2*FIELD_BITS-1:0] m_fields;

    assign s_op     = s_tdata[1:0];
    assign s_xfer   = s_tvalid && s_tready;
    assign m_status = m_tdata[1:0];
    assign m_fields = m_tdata[33:2];

    // Reset leaves no result pending.
    `ASSERT_NEXT_ALWAYS(a_reset_clears_result, aclk, !aresetn, !m_tvalid)

    // A stalled result transfer keeps its contents.
    `ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A request that gives a result keeps the input closed in the next cycle.
    `ASSERT_NEXT(a_busy_after_request, aclk, aresetn, s_xfer && (s_op != OP_UNUSED), !s_tready)

    // A failed request reports a zero address and a zero size.
    `ASSERT_IMPLIES(a_failure_is_zero, aclk, aresetn, m_tvalid && (m_status != ST_OK), m_fields == '0)

endmodule

bind first_fit_segment_allocator_core ffsa_checker u_ffsa_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for first_fit_segment_allocator_core.
// Needs ffsa_pkg and the allocator RTL. It keeps its own model of the free and
// allocated segment tables and checks every result transfer against it.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ffsa_pkg::*;

    localparam int ENTRIES       = DEFAULT_TABLE_ENTRIES;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;

    // One expected result transfer.
    typedef struct {
        status_t               status;
        logic [FIELD_BITS-1:0] address;
        logic [FIELD_BITS-1:0] seg_size;
    } reply_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    // s_tdata: operation[1:0], request_size[17:2], release_address[33:18], zero[39:34].
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // m_tdata: status[1:0], address[17:2], segment_size[33:18], zero[39:34].
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    cfg_wr_en = 1'b0;
    logic                    cfg_index = REG_HEAP_BASE;
    logic [FIELD_BITS-1:0]   cfg_wdata = '0;

    // Model state: configuration, free segments in scan order, allocated slots.
    logic [FIELD_BITS-1:0] heap_base_cfg = HEAP_BASE_RESET;
    logic [FIELD_BITS-1:0] heap_size_cfg = HEAP_SIZE_RESET;
    logic [FIELD_BITS-1:0] hole_base [ENTRIES];
    logic [FIELD_BITS-1:0] hole_len [ENTRIES];
    int                    hole_count = 0;
    logic [FIELD_BITS-1:0] grant_base [ENTRIES];
    logic [FIELD_BITS-1:0] grant_len [ENTRIES];
    bit                    grant_live [ENTRIES];

    reply_t pending_replies[$];
    int     error_count = 0;
    int     burst_left = 0;
    int     quiet_cycles = 0;
    int     pace_count = 0;
    bit     back_to_back = 1'b0;
    bit     hold_results = 1'b0;

    first_fit_segment_allocator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Applies one accepted request to the model; returns 0 when no result is due.
    function automatic bit apply_request(input logic [OP_BITS-1:0] op,
                                         input logic [FIELD_BITS-1:0] size,
                                         input logic [FIELD_BITS-1:0] addr,
                                         output reply_t r);
        int slot;
        int idx;
        r.status   = ST_OK;
        r.address  = '0;
        r.seg_size = '0;
        case (op)
            OP_ALLOC: begin
                slot = 0;
                while (slot < ENTRIES && grant_live[slot]) slot++;
                idx = 0;
                while (idx < hole_count && hole_len[idx] < size) idx++;
                if (size == 0) begin
                    r.status = ST_NOFIT;
                end else if (slot == ENTRIES) begin
                    r.status = ST_FULL;
                end else if (idx == hole_count) begin
                    r.status = ST_NOFIT;
                end else begin
                    r.address  = hole_base[idx];
                    r.seg_size = size;
                    if (hole_len[idx] == size) begin
                        // Exact fit: close the gap in the free list.
                        for (int k = idx; k < hole_count - 1; k++) begin
                            hole_base[k] = hole_base[k + 1];
                            hole_len[k]  = hole_len[k + 1];
                        end
                        hole_count--;
                    end else begin
                        // Split: the front goes out, the start wraps at 16 bits.
                        hole_base[idx] = hole_base[idx] + size;
                        hole_len[idx]  = hole_len[idx] - size;
                    end
                    grant_base[slot] = r.address;
                    grant_len[slot]  = size;
                    grant_live[slot] = 1'b1;
                end
            end
            OP_RELEASE: begin
                slot = 0;
                while (slot < ENTRIES && !(grant_live[slot] && grant_base[slot] == addr)) slot++;
                if (slot == ENTRIES) begin
                    r.status = ST_NOTALLOC;
                end else if (hole_count >= ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    // The released segment goes to the front, without merging.
                    for (int k = hole_count; k > 0; k--) begin
                        hole_base[k] = hole_base[k - 1];
                        hole_len[k]  = hole_len[k - 1];
                    end
                    hole_base[0]     = addr;
                    hole_len[0]      = grant_len[slot];
                    hole_count++;
                    grant_live[slot] = 1'b0;
                    r.address        = addr;
                    r.seg_size       = grant_len[slot];
                end
            end
            OP_INIT: begin
                for (int k = 0; k < ENTRIES; k++) grant_live[k] = 1'b0;
                if (heap_size_cfg != 0) begin
                    hole_base[0] = heap_base_cfg;
                    hole_len[0]  = heap_size_cfg;
                    hole_count   = 1;
                end else begin
                    hole_count = 0;
                end
                r.address  = heap_base_cfg;
                r.seg_size = heap_size_cfg;
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Offers one request in bursts with random gaps and records its expected result.
    task automatic send_request(input logic [OP_BITS-1:0] op,
                                input logic [FIELD_BITS-1:0] size,
                                input logic [FIELD_BITS-1:0] addr);
        int     gap;
        reply_t r;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
        if (back_to_back) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, addr, size, op};
        do @(posedge aclk); while (!s_tready);
        if (apply_request(op, size, addr, r)) pending_replies.push_back(r);
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both heap registers while the block is idle.
    task automatic configure_heap(input logic [FIELD_BITS-1:0] base,
                                  input logic [FIELD_BITS-1:0] length);
        wait_for_replies();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_HEAP_BASE;
        cfg_wdata <= base;
        @(posedge aclk);
        cfg_index <= REG_HEAP_SIZE;
        cfg_wdata <= length;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        heap_base_cfg = base;
        heap_size_cfg = length;
    endtask

    // Requests against empty tables, then an initialize from the reset defaults.
    task automatic test_empty_tables();
        send_request(OP_ALLOC, 16'd8, 16'd0);
        send_request(OP_RELEASE, 16'd0, 16'd5000);
        send_request(OP_UNUSED, 16'hFFFF, 16'hFFFF);
        send_request(OP_INIT, 16'd0, 16'd0);
        send_request(OP_ALLOC, 16'd15000, 16'd0);
    endtask

    // Address wrap, field extremes, zero request size and a zero-size heap.
    task automatic test_field_extremes();
        configure_heap(16'hFFF0, 16'h0030);
        send_request(OP_INIT, 16'd0, 16'd0);
        send_request(OP_ALLOC, 16'h0020, 16'd0);
        send_request(OP_ALLOC, 16'd0, 16'd0);
        send_request(OP_ALLOC, 16'hFFFF, 16'd0);
        send_request(OP_ALLOC, 16'h0010, 16'd0);
        send_request(OP_RELEASE, 16'd0, 16'hFFF0);
        send_request(OP_RELEASE, 16'd0, 16'hFFF0);
        send_request(OP_RELEASE, 16'hFFFF, 16'hFFFF);
        configure_heap(16'h0000, 16'hFFFF);
        send_request(OP_INIT, 16'd0, 16'd0);
        send_request(OP_ALLOC, 16'hFFFF, 16'd0);
        send_request(OP_RELEASE, 16'd0, 16'h0000);
        configure_heap(16'hFFFF, 16'd1);
        send_request(OP_INIT, 16'd0, 16'd0);
        send_request(OP_ALLOC, 16'd1, 16'd0);
        configure_heap(16'd300, 16'd0);
        send_request(OP_INIT, 16'd0, 16'd0);
        send_request(OP_ALLOC, 16'd1, 16'd0);
    endtask

    // Fills the allocated table, then the free table through releases.
    task automatic test_table_limits();
        configure_heap(16'd100, 16'd100);
        send_request(OP_INIT, 16'd0, 16'd0);
        for (int n = 0; n <= ENTRIES; n++) send_request(OP_ALLOC, 16'd1, 16'd0);
        for (int n = 0; n < ENTRIES; n++) send_request(OP_RELEASE, 16'd0, 16'(100 + n));
        send_request(OP_ALLOC, 16'd1, 16'd0);
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_result_backpressure();
        configure_heap(16'd2000, 16'd4000);
        send_request(OP_INIT, 16'd0, 16'd0);
        hold_results = 1'b1;
        back_to_back = 1'b1;
        for (int n = 0; n < 8; n++) send_request(OP_ALLOC, 16'd50, 16'd0);
        for (int n = 0; n < 4; n++) send_request(OP_RELEASE, 16'd0, 16'(2000 + 50 * n));
        back_to_back = 1'b0;
        wait_for_replies();
    endtask

    // Random traffic, mostly allocations and releases of live segments, over
    // several heap settings.
    task automatic test_random_traffic();
        logic [FIELD_BITS-1:0] base;
        logic [FIELD_BITS-1:0] length;
        logic [FIELD_BITS-1:0] size;
        logic [FIELD_BITS-1:0] addr;
        int                    roll;
        int                    first;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin base = 16'd5000; length = 16'd15000; end
                1: begin base = 16'h0000; length = 16'hFFFF; end
                2: begin base = 16'hFFFF; length = 16'd300; end
                3: begin base = 16'($urandom()); length = 16'($urandom_range(64, 2048)); end
                default: begin
                    base = 16'($urandom());
                    length = 16'($urandom_range(1, 65535));
                end
            endcase
            configure_heap(base, length);
            send_request(OP_INIT, 16'($urandom()), 16'($urandom()));
            for (int n = 0; n < 80; n++) begin
                roll = $urandom_range(0, 99);
                size = 16'($urandom());
                addr = 16'($urandom());
                if (roll < 50) begin
                    // Sizes mostly scaled to the heap so that the list fragments.
                    roll = $urandom_range(0, 19);
                    if (roll < 13) size = 16'($urandom_range(1, (length > 12) ? length / 12 : 1));
                    else if (roll < 18) size = 16'($urandom_range(1, 16));
                    else if (roll == 18) size = 16'd0;
                    send_request(OP_ALLOC, size, addr);
                end else if (roll < 85) begin
                    // Release a live segment, starting the search at a random slot.
                    first = $urandom_range(0, ENTRIES - 1);
                    for (int k = 0; k < ENTRIES; k++) begin
                        if (grant_live[(first + k) % ENTRIES]) begin
                            addr = grant_base[(first + k) % ENTRIES];
                            break;
                        end
                    end
                    send_request(OP_RELEASE, size, addr);
                end else if (roll < 92) begin
                    send_request(OP_RELEASE, size, addr);
                end else if (roll < 96) begin
                    send_request(OP_INIT, size, addr);
                end else begin
                    send_request(OP_UNUSED, size, addr);
                end
            end
        end
    endtask

    // Receiver pacing: a rotating stall pattern, or a long hold-off on request.
    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end else begin
                pace_count++;
                case ((pace_count / 50) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (pace_count % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Each result transfer is checked against the oldest expectation.
    always @(posedge aclk) begin : result_check
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("result transfer with nothing expected, m_tdata %h", m_tdata);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[17:2] !== want.address) begin
                    $error("address expected %h actual %h", want.address, m_tdata[17:2]);
                    error_count++;
                end
                if (m_tdata[33:18] !== want.seg_size) begin
                    $error("segment_size expected %h actual %h", want.seg_size, m_tdata[33:18]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_tables();
        test_field_extremes();
        test_table_limits();
        test_result_backpressure();
        test_random_traffic();
        wait_for_replies();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ffsa_pkg.sv
rtl/ffsa_ram.sv
rtl/first_fit_segment_allocator_core.sv
rtl/ffsa_checker.sv
sim/testbench.sv
